### design/gbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int COORD_W  = 15;
    localparam int SIZE_W   = 14;
    localparam int AREA_W   = 28;
    localparam int UNION_W  = 29;
    localparam int THRESH_W = 16;
    localparam int SLOT_W   = 6;
    localparam int PROD_W   = THRESH_W + UNION_W;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd29491;

    // One stored box: geometry plus its precomputed area.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [AREA_W-1:0]         area;
    } kept_entry_t;

    localparam int ENTRY_W = $bits(kept_entry_t);

    // Status from the overlap test pipeline back to the controller.
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } iou_status_t;

endpackage : gbn_pkg
`default_nettype wire

### design/gbn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channels for box requests and suppression results.
// ----------------------------------------------------------------------------
interface gbn_box_if
    import gbn_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      first_of_set;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;

    modport source (
        output valid, first_of_set, box_left, box_top, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, first_of_set, box_left, box_top, box_width, box_height,
        output ready
    );
endinterface : gbn_box_if

interface gbn_res_if
    import gbn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              keep;
    logic [SLOT_W-1:0] kept_slot;
    logic              table_overflow;

    modport source (
        output valid, keep, kept_slot, table_overflow,
        input  ready
    );
    modport sink (
        input  valid, keep, kept_slot, table_overflow,
        output ready
    );
endinterface : gbn_res_if
`default_nettype wire

### design/gbn_table_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_table_mem
// Kept box table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbn_table_mem
    import gbn_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic         clk,
    input  wire logic         we,
    input  wire logic [AW-1:0] waddr,
    input  wire kept_entry_t  wdata,
    input  wire logic         re,
    input  wire logic [AW-1:0] raddr,
    output kept_entry_t       rdata
);

    kept_entry_t mem_array [DEPTH];
    kept_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : gbn_table_mem
`default_nettype wire

### design/gbn_iou_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_iou_test
// Five-stage pipeline: overlap spans, intersection, union, threshold
// product, and the exact inter*2^16 > thr*union compare.
// ----------------------------------------------------------------------------
module gbn_iou_test
    import gbn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire kept_entry_t         entry,
    input  wire kept_entry_t         cand,
    input  wire logic [THRESH_W-1:0] thresh,
    output iou_status_t              status
);

    localparam int EXT_W = COORD_W + 2;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SIZE_W-1:0]  iw1_reg, ih1_reg;
    logic [AREA_W-1:0]  areab1_reg, areab2_reg;
    logic [AREA_W-1:0]  inter2_reg, inter3_reg, inter4_reg;
    logic [UNION_W-1:0] uni3_reg;
    logic [PROD_W-1:0]  prod4_reg;
    logic               hit5_reg;

    logic [SIZE_W-1:0]  iw_next, ih_next;

    // Overlap of [a0, a0+al) and [b0, b0+bl), clamped at zero.
    function automatic logic [SIZE_W-1:0] span(
        input logic signed [COORD_W-1:0] a0,
        input logic [SIZE_W-1:0]         al,
        input logic signed [COORD_W-1:0] b0,
        input logic [SIZE_W-1:0]         bl
    );
        logic signed [EXT_W-1:0] ax, bx, ae, be, lo, hi, d;
        ax = EXT_W'(a0);
        bx = EXT_W'(b0);
        ae = ax + $signed({3'b000, al});
        be = bx + $signed({3'b000, bl});
        lo = (ax > bx) ? ax : bx;
        hi = (ae < be) ? ae : be;
        d  = hi - lo;
        return (d > 0) ? d[SIZE_W-1:0] : '0;
    endfunction

    always_comb
    begin
        iw_next = span(cand.left, cand.width, entry.left, entry.width);
        ih_next = span(cand.top, cand.height, entry.top, entry.height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iw1_reg    <= iw_next;
        ih1_reg    <= ih_next;
        areab1_reg <= entry.area;

        inter2_reg <= iw1_reg * ih1_reg;
        areab2_reg <= areab1_reg;

        // inter never exceeds either area, so the union stays non-negative
        uni3_reg   <= {1'b0, cand.area} + {1'b0, areab2_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;

        prod4_reg  <= thresh * uni3_reg;
        inter4_reg <= inter3_reg;

        hit5_reg   <= {1'b0, inter4_reg, 16'h0000} > prod4_reg;
    end

    assign status.busy      = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit_valid = v5_reg;
    assign status.hit       = hit5_reg;

endmodule : gbn_iou_test
`default_nettype wire

### design/greedy_box_nms.sv
`default_nettype none
// Requests: one at a time; a new request is taken only in idle, after the last result is registered.
// The scan is set by the single read port of the kept table, one stored box compared
//   per cycle, plus the compare pipeline.
// Reset: kept count cleared, threshold back to 0.45; table contents are left
//   as they are and only entries below the count are ever read.
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over a kept box table held in memory.
// ----------------------------------------------------------------------------
module greedy_box_nms
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [THRESH_W-1:0] cfg_wdata,
    gbn_box_if.sink                  req,
    gbn_res_if.source                res
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [THRESH_W-1:0] thresh_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                rd_valid_reg;
    logic                suppress_reg, suppress_next;
    kept_entry_t         cand_reg;

    logic                out_valid_reg, out_valid_next;
    logic                out_keep_reg, out_keep_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                accept;
    logic                rd_en;
    logic                wr_en;
    logic                full;
    logic                finish;
    kept_entry_t         rd_data;
    iou_status_t         iou_st;

    assign accept  = req.valid && req.ready;
    assign full    = (count_reg == CW'(MAX_KEPT));
    assign finish  = (state_reg == ST_DRAIN) && !iou_st.busy && !rd_valid_reg
                     && (!out_valid_reg || res.ready);
    assign rd_en   = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign wr_en   = finish && !suppress_reg && !full;
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        suppress_next  = suppress_reg;
        out_valid_next = out_valid_reg;
        out_keep_next  = out_keep_reg;
        out_slot_next  = out_slot_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (iou_st.hit_valid && iou_st.hit)
        begin
            suppress_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    suppress_next = 1'b0;
                    rd_idx_next   = '0;
                    if (req.first_of_set)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    out_keep_next  = !suppress_reg;
                    out_ovf_next   = !suppress_reg && full;
                    out_slot_next  = wr_en ? SLOT_W'(count_reg) : '0;
                    if (wr_en)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thresh_reg    <= THRESH_RESET;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            suppress_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_valid_reg  <= rd_en;
            suppress_reg  <= suppress_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_keep_reg <= out_keep_next;
        out_slot_reg <= out_slot_next;
        out_ovf_reg  <= out_ovf_next;
        if (accept)
        begin
            cand_reg.left   <= req.box_left;
            cand_reg.top    <= req.box_top;
            cand_reg.width  <= req.box_width;
            cand_reg.height <= req.box_height;
            cand_reg.area   <= req.box_width * req.box_height;
        end
    end

    gbn_table_mem #(
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (cand_reg),
        .re    (rd_en),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    gbn_iou_test u_iou (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .entry    (rd_data),
        .cand     (cand_reg),
        .thresh   (thresh_reg),
        .status   (iou_st)
    );

    assign res.valid          = out_valid_reg;
    assign res.keep           = out_keep_reg;
    assign res.kept_slot      = out_slot_reg;
    assign res.table_overflow = out_ovf_reg;

endmodule : greedy_box_nms
`default_nettype wire
